FILE: hdl/tos_pkg.sv
// ----------------------------------------------------------------------------
// tos_pkg
// Shared types and constants for the typed operand stack.
// ----------------------------------------------------------------------------
`default_nettype none

package tos_pkg;

  localparam int unsigned DepthDefault = 256;

  localparam int unsigned ValW = 32;
  localparam int unsigned TagW = 2;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_LOAD  = 3'd3,
    CMD_STORE = 3'd4,
    CMD_INC   = 3'd5,
    CMD_DROP  = 3'd6,
    CMD_REL   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_TYPE  = 3'd3,
    ST_RANGE = 3'd4
  } status_e;

  localparam logic [TagW-1:0] TAG_INT = 2'd0;
  localparam logic [TagW-1:0] TAG_REF = 2'd1;
  localparam logic [TagW-1:0] TAG_BAD = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request fields, start entry read
    logic commit;   // evaluate, update store and pointer, load result
  } ctl_t;

endpackage

`default_nettype wire

FILE: hdl/tos_ctrl.sv
// ----------------------------------------------------------------------------
// tos_ctrl
// Sequencer: accept a request, run the execute state, manage result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tos_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tos_pkg::ctl_t      ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    ctl_o.capture = 1'b0;
    ctl_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold here until the result register can take the new result
        if (slot_free) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.capture |=> (state_q == S_EXEC))
    else $error("capture not followed by execute");

  a_commit_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |-> (state_q == S_EXEC) && slot_free)
    else $error("commit outside execute or into a full result slot");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |=> out_valid_q)
    else $error("result not presented after commit");

  a_exec_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && !slot_free |=> (state_q == S_EXEC))
    else $error("execute left while result slot full");
`endif

endmodule

`default_nettype wire

FILE: hdl/tos_dpath.sv
// ----------------------------------------------------------------------------
// tos_dpath
// Entry store, stack pointer, request checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tos_dpath #(
  parameter int unsigned STACK_DEPTH = tos_pkg::DepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tos_pkg::ctl_t      ctl_i,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [31:0]        value_i,
  input  wire logic [1:0]         type_tag_i,
  input  wire logic [7:0]         frame_base_i,
  input  wire logic [7:0]         local_index_i,
  input  wire logic signed [7:0]  sp_offset_i,
  input  wire logic [7:0]         drop_count_i,
  output logic [31:0]             result_value_o,
  output logic [1:0]              result_tag_o,
  output logic                    is_null_o,
  output logic [2:0]              status_o,
  output logic [8:0]              stack_depth_o
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW  = ((SPW > 8) ? SPW : 8) + 1;
  localparam int unsigned EW  = tos_pkg::ValW + tos_pkg::TagW;

  // entry store: {tag, value}
  logic [EW-1:0] mem_q [STACK_DEPTH];
  logic [EW-1:0] rd_q;

  logic [SPW-1:0] sp_q, sp_d;

  // latched request
  logic [2:0]    cmd_q;
  logic [31:0]   val_q;
  logic [1:0]    tag_q;
  logic [7:0]    cnt_q;
  logic [AW-1:0] iaddr_q;
  logic          idx_ok_q;
  logic          rel_ok_q;

  // capture-cycle address logic
  logic [8:0]           idx_sum;
  logic [31:0]          idx_ext;
  logic                 idx_ok;
  logic signed [PW-1:0] pos;
  logic                 rel_ok;
  logic [31:0]          sp_ext;
  logic [31:0]          spm1_ext;
  logic [31:0]          pos_ext;
  logic [AW-1:0]        raddr;

  assign idx_sum  = {1'b0, frame_base_i} + {1'b0, local_index_i};
  assign idx_ext  = 32'(idx_sum);
  assign idx_ok   = idx_ext < 32'(STACK_DEPTH);
  assign pos      = PW'($signed({1'b0, sp_q})) + PW'(sp_offset_i);
  assign rel_ok   = !pos[PW-1] && (32'($unsigned(pos)) < 32'(STACK_DEPTH));
  assign sp_ext   = 32'(sp_q);
  assign spm1_ext = 32'(sp_q - SPW'(1));
  assign pos_ext  = 32'($unsigned(pos));

  always_comb begin
    unique case (tos_pkg::cmd_e'(cmd_i))
      tos_pkg::CMD_POP,
      tos_pkg::CMD_STORE: raddr = spm1_ext[AW-1:0];
      tos_pkg::CMD_REL:   raddr = pos_ext[AW-1:0];
      default:            raddr = idx_ext[AW-1:0];
    endcase
  end

  // execute-cycle evaluation
  logic [31:0]       rd_val;
  logic [1:0]        rd_tag;
  logic              full;
  logic              empty;
  logic [31:0]       inc_sum;
  tos_pkg::status_e  st;
  logic [31:0]       r_val;
  logic [1:0]        r_tag;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [EW-1:0]     wdata;
  logic [31:0]       sp_d_ext;

  assign rd_val  = rd_q[31:0];
  assign rd_tag  = rd_q[EW-1:32];
  assign full    = sp_ext >= 32'(STACK_DEPTH);
  assign empty   = (sp_q == '0);
  assign inc_sum = rd_val + val_q;

  always_comb begin
    st    = tos_pkg::ST_OK;
    r_val = '0;
    r_tag = tos_pkg::TAG_INT;
    we    = 1'b0;
    waddr = iaddr_q;
    wdata = {tag_q, rd_val};
    sp_d  = sp_q;
    unique case (tos_pkg::cmd_e'(cmd_q))
      tos_pkg::CMD_PUSH: begin
        if (tag_q == tos_pkg::TAG_BAD) begin
          st = tos_pkg::ST_TYPE;
        end else if (full) begin
          st = tos_pkg::ST_OVER;
        end else begin
          we    = 1'b1;
          waddr = sp_ext[AW-1:0];
          wdata = {tag_q, val_q};
          sp_d  = sp_q + SPW'(1);
        end
      end
      tos_pkg::CMD_POP: begin
        if (empty) begin
          st = tos_pkg::ST_UNDER;
        end else if (rd_tag != tag_q) begin
          st = tos_pkg::ST_TYPE;
        end else begin
          sp_d  = sp_q - SPW'(1);
          r_val = rd_val;
          r_tag = rd_tag;
        end
      end
      tos_pkg::CMD_PEEK: begin
        if (!idx_ok_q) begin
          st = tos_pkg::ST_RANGE;
        end else if (rd_tag != tag_q) begin
          st = tos_pkg::ST_TYPE;
        end else begin
          r_val = rd_val;
          r_tag = tag_q;
        end
      end
      tos_pkg::CMD_LOAD: begin
        if (!idx_ok_q) begin
          st = tos_pkg::ST_RANGE;
        end else if (rd_tag != tag_q) begin
          st = tos_pkg::ST_TYPE;
        end else if (full) begin
          st = tos_pkg::ST_OVER;
        end else begin
          we    = 1'b1;
          waddr = sp_ext[AW-1:0];
          sp_d  = sp_q + SPW'(1);
          r_val = rd_val;
          r_tag = tag_q;
        end
      end
      tos_pkg::CMD_STORE: begin
        if (empty) begin
          st = tos_pkg::ST_UNDER;
        end else if (!idx_ok_q) begin
          st = tos_pkg::ST_RANGE;
        end else if (rd_tag != tag_q) begin
          st = tos_pkg::ST_TYPE;
        end else begin
          we    = 1'b1;
          sp_d  = sp_q - SPW'(1);
          r_val = rd_val;
          r_tag = tag_q;
        end
      end
      tos_pkg::CMD_INC: begin
        if (!idx_ok_q) begin
          st = tos_pkg::ST_RANGE;
        end else if (rd_tag != tos_pkg::TAG_INT) begin
          st = tos_pkg::ST_TYPE;
        end else begin
          we    = 1'b1;
          wdata = {tos_pkg::TAG_INT, inc_sum};
          r_val = inc_sum;
        end
      end
      tos_pkg::CMD_DROP: begin
        // pointer must stay above zero after the drop
        if (sp_ext > 32'(cnt_q)) begin
          sp_d = sp_q - SPW'(cnt_q);
        end else begin
          st = tos_pkg::ST_UNDER;
        end
      end
      tos_pkg::CMD_REL: begin
        if (!rel_ok_q) begin
          st = tos_pkg::ST_RANGE;
        end else begin
          r_val = rd_val;
          r_tag = rd_tag;
        end
      end
      default: st = tos_pkg::ST_OK;
    endcase
  end

  assign sp_d_ext = 32'(sp_d);

  // store: registered read at capture, write at commit
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      rd_q <= mem_q[raddr];
    end
    if (ctl_i.commit && we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q    <= cmd_i;
      val_q    <= value_i;
      tag_q    <= type_tag_i;
      cnt_q    <= drop_count_i;
      iaddr_q  <= idx_ext[AW-1:0];
      idx_ok_q <= idx_ok;
      rel_ok_q <= rel_ok;
    end
    if (ctl_i.commit) begin
      result_value_o <= r_val;
      result_tag_o   <= r_tag;
      is_null_o      <= (st == tos_pkg::ST_OK) && (r_tag == tos_pkg::TAG_REF) &&
                        (r_val == '0);
      status_o       <= st;
      stack_depth_o  <= sp_d_ext[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (ctl_i.commit) begin
      sp_q <= sp_d;
    end
  end

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= 32'(STACK_DEPTH))
    else $error("stack pointer beyond store depth");

  a_sp_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.commit |=> $stable(sp_q))
    else $error("stack pointer moved without commit");
`endif

endmodule

`default_nettype wire

FILE: hdl/typed_operand_stack.sv
// ----------------------------------------------------------------------------
// typed_operand_stack
// Typed operand stack store for a bytecode interpreter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries one command with its
//   operands; response channel (out_valid_o/out_ready_i) returns exactly one
//   result per request: value, tag, null flag, status and the new depth.
//   A failing command only reports its status; store and pointer are kept.
//   On accept the operands are latched and the entry read is registered;
//   the execute state then checks the request, writes the store and loads
//   the result register. A new request is taken only after execute ends,
//   as the single-port entry memory is read on accept, written in execute.
//   The result sits in an output register, so the next request is taken
//   while the previous result still waits. If the receiver stalls, the
//   execute state of the following request holds until the slot frees.
//   Reset clears the stack pointer and the handshake state; entry contents
//   are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_operand_stack #(
  parameter int unsigned STACK_DEPTH = tos_pkg::DepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [31:0]        value_i,
  input  wire logic [1:0]         type_tag_i,
  input  wire logic [7:0]         frame_base_i,
  input  wire logic [7:0]         local_index_i,
  input  wire logic signed [7:0]  sp_offset_i,
  input  wire logic [7:0]         drop_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             result_value_o,
  output logic [1:0]              result_tag_o,
  output logic                    is_null_o,
  output logic [2:0]              status_o,
  output logic [8:0]              stack_depth_o
);

  tos_pkg::ctl_t ctl;

  tos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  tos_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .type_tag_i     (type_tag_i),
    .frame_base_i   (frame_base_i),
    .local_index_i  (local_index_i),
    .sp_offset_i    (sp_offset_i),
    .drop_count_i   (drop_count_i),
    .result_value_o (result_value_o),
    .result_tag_o   (result_tag_o),
    .is_null_o      (is_null_o),
    .status_o       (status_o),
    .stack_depth_o  (stack_depth_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the typed operand stack. A mirror of the stack
// (entries, tags, written marks, pointer) predicts the response to every
// accepted request; responses are checked in order. A short directed
// sequence covers the error cases, then random traffic runs under three
// handshake idle profiles, including a long response stall and a fill to
// full depth.
// ----------------------------------------------------------------------------
module testbench;

  localparam int Depth = tos_pkg::DepthDefault;
  localparam logic [tos_pkg::TagW-1:0] TagU2 = 2'd2;
  localparam int HoldCycles = 400;
  localparam int Timeout = 2000;

  typedef struct packed {
    tos_pkg::cmd_e      cmd;
    logic [31:0]        value;
    logic [1:0]         tag;
    logic [7:0]         frame_base;
    logic [7:0]         local_index;
    logic signed [7:0]  sp_offset;
    logic [7:0]         drop_count;
  } stack_req_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [1:0]       tag;
    logic             is_null;
    tos_pkg::status_e status;
    logic [8:0]       depth;
  } stack_resp_t;

  // Shadow copy of the operand stack; predicts one response per request.
  class operand_stack_mirror;
    logic [31:0] values [Depth];
    logic [1:0]  tags [Depth];
    bit          written [Depth];
    int          sp;
    stack_resp_t pending_results [$];
    int          errors;

    function void write_entry(int at, logic [31:0] v, logic [1:0] t);
      values[at] = v;
      tags[at] = t;
      written[at] = 1'b1;
    endfunction

    function void apply_request(stack_req_t r);
      stack_resp_t e;
      int idx;
      int pos;
      logic [31:0] v;
      e = '0;
      idx = int'(r.frame_base) + int'(r.local_index);
      case (r.cmd)
        tos_pkg::CMD_PUSH: begin
          if (r.tag == tos_pkg::TAG_BAD) e.status = tos_pkg::ST_TYPE;
          else if (sp >= Depth) e.status = tos_pkg::ST_OVER;
          else begin
            write_entry(sp, r.value, r.tag);
            sp++;
          end
        end
        tos_pkg::CMD_POP: begin
          if (sp == 0) e.status = tos_pkg::ST_UNDER;
          else if (tags[sp-1] != r.tag) e.status = tos_pkg::ST_TYPE;
          else begin
            sp--;
            e.value = values[sp];
            e.tag = tags[sp];
          end
        end
        tos_pkg::CMD_PEEK: begin
          if (idx >= Depth) e.status = tos_pkg::ST_RANGE;
          else if (tags[idx] != r.tag) e.status = tos_pkg::ST_TYPE;
          else begin
            e.value = values[idx];
            e.tag = r.tag;
          end
        end
        tos_pkg::CMD_LOAD: begin
          if (idx >= Depth) e.status = tos_pkg::ST_RANGE;
          else if (tags[idx] != r.tag) e.status = tos_pkg::ST_TYPE;
          else if (sp >= Depth) e.status = tos_pkg::ST_OVER;
          else begin
            v = values[idx];
            write_entry(sp, v, r.tag);
            sp++;
            e.value = v;
            e.tag = r.tag;
          end
        end
        tos_pkg::CMD_STORE: begin
          // underflow wins over a bad index, index over the type check
          if (sp == 0) e.status = tos_pkg::ST_UNDER;
          else if (idx >= Depth) e.status = tos_pkg::ST_RANGE;
          else if (tags[sp-1] != r.tag) e.status = tos_pkg::ST_TYPE;
          else begin
            sp--;
            v = values[sp];
            write_entry(idx, v, r.tag);
            e.value = v;
            e.tag = r.tag;
          end
        end
        tos_pkg::CMD_INC: begin
          if (idx >= Depth) e.status = tos_pkg::ST_RANGE;
          else if (tags[idx] != tos_pkg::TAG_INT) e.status = tos_pkg::ST_TYPE;
          else begin
            values[idx] = values[idx] + r.value;
            e.value = values[idx];
            e.tag = tos_pkg::TAG_INT;
          end
        end
        tos_pkg::CMD_DROP: begin
          // pointer must stay above zero, so a drop of everything fails
          if (sp > int'(r.drop_count)) sp -= int'(r.drop_count);
          else e.status = tos_pkg::ST_UNDER;
        end
        default: begin
          pos = sp + int'(r.sp_offset);
          if (pos < 0 || pos >= Depth) e.status = tos_pkg::ST_RANGE;
          else begin
            e.value = values[pos];
            e.tag = tags[pos];
          end
        end
      endcase
      e.is_null = (e.status == tos_pkg::ST_OK) && (e.tag == tos_pkg::TAG_REF) &&
                  (e.value == '0);
      e.depth = sp[8:0];
      pending_results.push_back(e);
    endfunction

    function void check_result(stack_resp_t got);
      stack_resp_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: response with no request pending: value %h status %0d", $time,
                 got.value, got.status);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got !== e) begin
        $display({"%0t: mismatch exp/act value %h/%h tag %0d/%0d null %0d/%0d",
                  " status %0d/%0d depth %0d/%0d"},
                 $time, e.value, got.value, e.tag, got.tag, e.is_null, got.is_null,
                 e.status, got.status, e.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [2:0]         req_cmd = '0;
  logic [31:0]        req_value = '0;
  logic [1:0]         req_tag = '0;
  logic [7:0]         req_frame_base = '0;
  logic [7:0]         req_local_index = '0;
  logic signed [7:0]  req_sp_offset = '0;
  logic [7:0]         req_drop_count = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic [31:0]        res_value;
  logic [1:0]         res_tag;
  logic               res_null;
  logic [2:0]         res_status;
  logic [8:0]         res_depth;

  operand_stack_mirror sb = new;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  bit filling = 1'b0;
  int fill_tail = 0;
  int stall_count = 0;

  typed_operand_stack #(.STACK_DEPTH(Depth)) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (req_valid),
    .in_ready_o     (req_ready),
    .cmd_i          (req_cmd),
    .value_i        (req_value),
    .type_tag_i     (req_tag),
    .frame_base_i   (req_frame_base),
    .local_index_i  (req_local_index),
    .sp_offset_i    (req_sp_offset),
    .drop_count_i   (req_drop_count),
    .out_valid_o    (rsp_valid),
    .out_ready_i    (rsp_ready),
    .result_value_o (res_value),
    .result_tag_o   (res_tag),
    .is_null_o      (res_null),
    .status_o       (res_status),
    .stack_depth_o  (res_depth)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) begin
      sb.check_result(stack_resp_t'{res_value, res_tag, res_null,
                                    tos_pkg::status_e'(res_status), res_depth});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= Timeout) begin
        $display("%0t: no handshake for %0d cycles", $time, Timeout);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // response side: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic stack_req_t req(tos_pkg::cmd_e c, logic [31:0] v, logic [1:0] t,
                                     logic [7:0] fb, logic [7:0] li,
                                     logic signed [7:0] off, logic [7:0] cnt);
    return '{c, v, t, fb, li, off, cnt};
  endfunction

  task automatic send_command(input stack_req_t r);
    req_valid <= 1'b1;
    req_cmd <= r.cmd;
    req_value <= r.value;
    req_tag <= r.tag;
    req_frame_base <= r.frame_base;
    req_local_index <= r.local_index;
    req_sp_offset <= r.sp_offset;
    req_drop_count <= r.drop_count;
    do @(posedge clk); while (!req_ready);
    sb.apply_request(r);
  endtask

  // Mostly well-formed commands aimed at live entries; the rest is noise.
  // Never reads an entry that was never written.
  function automatic stack_req_t random_command();
    stack_req_t r;
    int idx;
    int pos;
    int pick;
    int tries;
    bit bad;
    tries = 0;
    if (filling && sb.sp == Depth) fill_tail++;
    do begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: r.value = 32'h0000_0000;
          1: r.value = 32'hffff_ffff;
          2: r.value = 32'h8000_0000;
          default: r.value = 32'h7fff_ffff;
        endcase
      end else begin
        r.value = $urandom();
      end
      r.tag = 2'($urandom_range(3));
      r.frame_base = 8'($urandom_range(255));
      r.local_index = 8'($urandom_range(255));
      r.sp_offset = 8'($urandom_range(255));
      r.drop_count = 8'($urandom_range(255));
      pick = int'($urandom_range(99));
      if (pick < 22) r.cmd = tos_pkg::CMD_PUSH;
      else if (pick < 36) r.cmd = tos_pkg::CMD_POP;
      else if (pick < 48) r.cmd = tos_pkg::CMD_PEEK;
      else if (pick < 58) r.cmd = tos_pkg::CMD_LOAD;
      else if (pick < 68) r.cmd = tos_pkg::CMD_STORE;
      else if (pick < 78) r.cmd = tos_pkg::CMD_INC;
      else if (pick < 87) r.cmd = tos_pkg::CMD_DROP;
      else r.cmd = tos_pkg::CMD_REL;
      if (filling) begin
        // climb to full depth, then try overflow and far reads, then drain
        case (fill_tail)
          0: begin
            if ($urandom_range(4) == 0) r.cmd = tos_pkg::CMD_LOAD;
            else r.cmd = tos_pkg::CMD_PUSH;
          end
          1: r.cmd = tos_pkg::CMD_PUSH;
          2: r.cmd = tos_pkg::CMD_LOAD;
          3: r.cmd = tos_pkg::CMD_REL;
          default: r.cmd = tos_pkg::CMD_DROP;
        endcase
      end
      if (filling || $urandom_range(99) < 85) begin
        case (r.cmd)
          tos_pkg::CMD_PUSH: r.tag = 2'($urandom_range(2));
          tos_pkg::CMD_POP, tos_pkg::CMD_STORE: begin
            if (sb.sp > 0) r.tag = sb.tags[sb.sp-1];
            if (r.cmd == tos_pkg::CMD_STORE) begin
              r.local_index = 8'($urandom_range(Depth - 1 - int'(r.frame_base)));
            end
          end
          tos_pkg::CMD_PEEK, tos_pkg::CMD_LOAD, tos_pkg::CMD_INC: begin
            idx = (sb.sp > 0) ? int'($urandom_range(sb.sp - 1)) : -1;
            if ($urandom_range(3) == 0) begin
              pos = int'($urandom_range(Depth - 1));
              if (sb.written[pos]) idx = pos;
            end
            if (idx >= 0) begin
              r.frame_base = 8'($urandom_range(idx));
              r.local_index = 8'(idx - int'(r.frame_base));
              if (r.cmd != tos_pkg::CMD_INC) r.tag = sb.tags[idx];
            end
          end
          tos_pkg::CMD_DROP: begin
            if (sb.sp > 1) r.drop_count = 8'($urandom_range((sb.sp > 7) ? 6 : sb.sp - 1));
            else r.drop_count = 8'd0;
          end
          default: begin
            if (sb.sp > 0) begin
              r.sp_offset = 8'(-$urandom_range((sb.sp > 128) ? 128 : sb.sp, 1));
            end
          end
        endcase
      end
      if (filling && fill_tail == 3) r.sp_offset = 8'sd127;
      if (filling && fill_tail >= 4) r.drop_count = 8'($urandom_range(255, 160));
      idx = int'(r.frame_base) + int'(r.local_index);
      pos = sb.sp + int'(r.sp_offset);
      case (r.cmd)
        tos_pkg::CMD_PEEK, tos_pkg::CMD_LOAD, tos_pkg::CMD_INC:
          bad = (idx < Depth) && !sb.written[idx];
        tos_pkg::CMD_REL: bad = (pos >= 0) && (pos < Depth) && !sb.written[pos];
        default: bad = 1'b0;
      endcase
      tries++;
    end while (bad && tries < 50);
    if (bad) begin
      r.cmd = tos_pkg::CMD_PUSH;
      r.tag = tos_pkg::TAG_INT;
    end
    if (fill_tail >= 4) begin
      filling = 1'b0;
      fill_tail = 0;
    end
    return r;
  endfunction

  task automatic run_random(input int count);
    repeat (count) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
      send_command(random_command());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack and out-of-store indexes
    send_command(req(tos_pkg::CMD_POP, 0, tos_pkg::TAG_INT, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_STORE, 0, tos_pkg::TAG_INT, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_DROP, 0, tos_pkg::TAG_INT, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_REL, 0, tos_pkg::TAG_INT, 0, 0, -1, 0));
    send_command(req(tos_pkg::CMD_REL, 0, tos_pkg::TAG_INT, 0, 0, -128, 0));
    send_command(req(tos_pkg::CMD_PEEK, 0, tos_pkg::TAG_INT, 255, 255, 0, 0));
    send_command(req(tos_pkg::CMD_LOAD, 0, tos_pkg::TAG_INT, 200, 56, 0, 0));
    send_command(req(tos_pkg::CMD_INC, 1, tos_pkg::TAG_INT, 255, 1, 0, 0));
    send_command(req(tos_pkg::CMD_PUSH, 32'h5555_aaaa, tos_pkg::TAG_BAD, 0, 0, 0, 0));
    // fill a few entries of each type, including a null reference
    send_command(req(tos_pkg::CMD_PUSH, 32'hffff_ffff, tos_pkg::TAG_INT, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_PUSH, 32'h0000_0000, tos_pkg::TAG_REF, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_PUSH, 32'h1234_5678, TagU2, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_PUSH, 32'h8000_0000, tos_pkg::TAG_REF, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_POP, 0, tos_pkg::TAG_INT, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_POP, 0, tos_pkg::TAG_REF, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_PEEK, 0, tos_pkg::TAG_REF, 0, 1, 0, 0));
    send_command(req(tos_pkg::CMD_PEEK, 0, TagU2, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_LOAD, 0, tos_pkg::TAG_INT, 0, 0, 0, 0));
    // increment wraps; a reference local is refused whatever the tag says
    send_command(req(tos_pkg::CMD_INC, 32'h0000_0001, tos_pkg::TAG_INT, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_INC, 32'h0000_0001, tos_pkg::TAG_REF, 0, 1, 0, 0));
    send_command(req(tos_pkg::CMD_INC, 32'hffff_ffff, tos_pkg::TAG_INT, 0, 0, 0, 0));
    send_command(req(tos_pkg::CMD_STORE, 0, tos_pkg::TAG_INT, 0, 9, 0, 0));
    send_command(req(tos_pkg::CMD_STORE, 0, TagU2, 255, 255, 0, 0));
    send_command(req(tos_pkg::CMD_STORE, 0, tos_pkg::TAG_INT, 0, 2, 0, 0));
    send_command(req(tos_pkg::CMD_REL, 0, tos_pkg::TAG_INT, 0, 0, -1, 0));
    send_command(req(tos_pkg::CMD_DROP, 0, tos_pkg::TAG_INT, 0, 0, 0, 3));
    send_command(req(tos_pkg::CMD_DROP, 0, tos_pkg::TAG_INT, 0, 0, 0, 2));
    send_command(req(tos_pkg::CMD_PEEK, 0, tos_pkg::TAG_INT, 0, 9, 0, 0));

    tx_idle_pct = 9;
    rx_idle_pct = 57;
    run_random(430);
    tx_idle_pct = 57;
    rx_idle_pct = 9;
    run_random(430);
    // back-to-back requests against a long response stall, climbing to full
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    filling = 1'b1;
    hold_req = 1'b1;
    run_random(430);
    req_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/tos_pkg.sv
hdl/tos_ctrl.sv
hdl/tos_dpath.sv
hdl/typed_operand_stack.sv
tb/sv/testbench.sv
